// ===== rtl/pcf_pkg.sv =====
// Shared types and constants of the Potts cluster flip engine.
package pcf_pkg;

    // Lattice geometry; the side is a power of two so that row and column wrap as bit fields
    localparam int SIDE  = 128;
    localparam int CELLS = SIDE * SIDE;
    localparam int CW    = $clog2(SIDE);
    localparam int AW    = $clog2(CELLS);
    localparam int DPW   = AW + 1;
    localparam int DIRW  = 3;
    localparam int STW   = AW + DIRW;

    localparam logic [16:0] THRESH_RESET = 17'd36089;
    localparam logic [31:0] SEED_RESET   = 32'd1;
    localparam logic [31:0] LFSR_TAPS    = 32'hD000_0001;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_FLIP  = 2'd2,
        MODE_BOND  = 2'd3
    } t_mode;

    typedef enum logic {
        CFG_THRESH = 1'b0,
        CFG_SEED   = 1'b1
    } t_cfg_idx;

    typedef enum logic [DIRW-1:0] {
        DIR_RIGHT = 3'd0,
        DIR_LEFT  = 3'd1,
        DIR_DOWN  = 3'd2,
        DIR_UP    = 3'd3,
        DIR_DONE  = 3'd4
    } t_dir;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SEED,
        ST_EXPAND,
        ST_CHECK,
        ST_DRAW,
        ST_DECIDE,
        ST_POP,
        ST_CLEAR,
        ST_BOND,
        ST_FINISH
    } t_state;

    // Control of the random source
    typedef struct packed {
        logic        load;
        logic [31:0] seed;
        logic        step;
    } t_rng_ctl;

endpackage

// ===== rtl/pcf_chan_if.sv =====
// Input and result channel interfaces of the Potts cluster flip engine.
interface pcf_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [6:0] row;
    logic [6:0] col;
    logic       spin_value;

    modport source (output valid, output mode, output row, output col, output spin_value,
                    input ready);
    modport sink (input valid, input mode, input row, input col, input spin_value,
                  output ready);
endinterface

interface pcf_out_if;
    logic        valid;
    logic        ready;
    logic        spin_read;
    logic [15:0] tally;
    logic        status;

    modport source (output valid, output spin_read, output tally, output status,
                    input ready);
    modport sink (input valid, input spin_read, input tally, input status,
                  output ready);
endinterface

// ===== rtl/pcf_rng.sv =====
// Galois LFSR bond random source, eight shifts per step.
module pcf_rng (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pcf_pkg::t_rng_ctl i_ctl,
    output logic [15:0]      o_draw
);

    logic [31:0] r_lfsr;
    logic [31:0] n_lfsr;

    function automatic logic [31:0] step8(input logic [31:0] w);
        logic [31:0] v;
        v = w;
        for (int k = 0; k < 8; k++) begin
            v = v[0] ? ((v >> 1) ^ pcf_pkg::LFSR_TAPS) : (v >> 1);
        end
        return v;
    endfunction

    // Load on seed write (zero seed becomes one), advance on step
    always_comb begin
        n_lfsr = r_lfsr;
        if (i_ctl.load) begin
            n_lfsr = (i_ctl.seed == 32'd0) ? 32'd1 : i_ctl.seed;
        end else if (i_ctl.step) begin
            n_lfsr = step8(r_lfsr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= pcf_pkg::SEED_RESET;
        end else begin
            r_lfsr <= n_lfsr;
        end
    end

    assign o_draw = r_lfsr[15:0];

endmodule

// ===== rtl/potts_cluster_flip_engine.sv =====
// Potts lattice engine: spin access, Wolff cluster flip and bond count.
//
//  channel   dir  handshake      payload
//  i_in      in   valid/ready    mode, row, col, spin_value
//  o_out     out  valid/ready    spin_read, tally, status
//  i_cfg_*   in   write enable   register index, 32-bit data
//
// After reset the block clears spin and flag memories before taking items.
// A bond count sweeps the lattice once through two spin read ports. A cluster flip
// checks each neighbour try, draws a random number for each candidate, retires each
// site from the walk stack, then clears the flag memory.
// One item is in work at a time; a result waits in the output register while the next
// item is taken, and a full output register stalls only the finish step.
module potts_cluster_flip_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pcf_in_if.sink             i_in,
    pcf_out_if.source          o_out,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);

    localparam int AW  = pcf_pkg::AW;
    localparam int CW  = pcf_pkg::CW;
    localparam int DPW = pcf_pkg::DPW;
    localparam int STW = pcf_pkg::STW;
    localparam logic [AW-1:0]  LAST_SITE = AW'(pcf_pkg::CELLS - 1);
    localparam logic [DPW-1:0] CELLS_D   = DPW'(pcf_pkg::CELLS);

    // Memories
    logic           spin_mem  [pcf_pkg::CELLS];
    logic           visit_mem [pcf_pkg::CELLS];
    logic [STW-1:0] stack_mem [pcf_pkg::CELLS];

    pcf_pkg::t_state r_state, n_state;
    logic [16:0]     r_thr;
    logic [AW-1:0]   r_site, n_site;
    logic            r_snew, n_snew;
    logic            r_old, n_old;
    logic [AW-1:0]   r_top, n_top;
    logic [2:0]      r_dir, n_dir;
    logic [AW-1:0]   r_nb, n_nb;
    logic [DPW-1:0]  r_depth, n_depth;
    logic [15:0]     r_tally, n_tally;
    logic            r_res_spin, n_res_spin;
    logic            r_status, n_status;
    logic            r_half, n_half;
    logic [AW-1:0]   r_clr, n_clr;
    logic [DPW-1:0]  r_bidx, n_bidx;
    logic            r_bv, n_bv;
    logic [AW-1:0]   r_bsite, n_bsite;
    logic            r_first, n_first;
    logic            r_prev, n_prev;
    logic            r_ov;
    logic            r_o_spin;
    logic [15:0]     r_o_tally;
    logic            r_o_status;

    // Memory ports
    logic            spa_re, spb_re, sp_we, vis_re, vis_we, stk_re, stk_we;
    logic [AW-1:0]   spa_addr, spb_addr, sp_waddr, vis_raddr, vis_waddr;
    logic [AW-1:0]   stk_raddr, stk_waddr;
    logic            sp_wdata, vis_wdata;
    logic [STW-1:0]  stk_wdata;
    logic            r_spa_q, r_spb_q, r_vis_q;
    logic [STW-1:0]  r_stk_q;

    logic            in_xfer, out_free;
    logic [AW-1:0]   nb_site;
    logic [CW-1:0]   top_row, top_col;
    logic [1:0]      bond_add;
    logic [CW-1:0]   bcol;
    logic [15:0]     draw;
    pcf_pkg::t_rng_ctl rng_ctl;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_free = !r_ov || o_out.ready;
    assign i_in.ready = (r_state == pcf_pkg::ST_IDLE);

    // Neighbour of the top site in the current direction, with wraparound
    assign top_row = r_top[AW-1:CW];
    assign top_col = r_top[CW-1:0];
    always_comb begin
        case (r_dir)
            pcf_pkg::DIR_RIGHT: nb_site = {top_row, top_col + CW'(1)};
            pcf_pkg::DIR_LEFT:  nb_site = {top_row, top_col - CW'(1)};
            pcf_pkg::DIR_DOWN:  nb_site = {top_row + CW'(1), top_col};
            default:            nb_site = {top_row - CW'(1), top_col};
        endcase
    end

    // Equal bonds found for the site whose spins just came back
    assign bcol = r_bsite[CW-1:0];
    always_comb begin
        bond_add = 2'(r_spa_q == r_spb_q)
                 + 2'((bcol != CW'(0)) && (r_spa_q == r_prev))
                 + 2'((bcol == CW'(pcf_pkg::SIDE - 1)) && (r_spa_q == r_first));
    end

    // Random source
    always_comb begin
        rng_ctl.load = i_cfg_we && (i_cfg_idx == pcf_pkg::CFG_SEED);
        rng_ctl.seed = i_cfg_data;
        rng_ctl.step = (r_state == pcf_pkg::ST_DRAW);
    end

    pcf_rng u_rng (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (rng_ctl),
        .o_draw  (draw)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pcf_pkg::ST_INIT: begin
                if (r_clr == LAST_SITE) n_state = pcf_pkg::ST_IDLE;
            end
            pcf_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    case (i_in.mode)
                        pcf_pkg::MODE_WRITE: n_state = pcf_pkg::ST_FINISH;
                        pcf_pkg::MODE_READ:  n_state = pcf_pkg::ST_READ;
                        pcf_pkg::MODE_FLIP:  n_state = pcf_pkg::ST_SEED;
                        default:             n_state = pcf_pkg::ST_BOND;
                    endcase
                end
            end
            pcf_pkg::ST_READ: n_state = pcf_pkg::ST_FINISH;
            pcf_pkg::ST_SEED: begin
                n_state = (r_spa_q == r_snew) ? pcf_pkg::ST_FINISH : pcf_pkg::ST_EXPAND;
            end
            pcf_pkg::ST_EXPAND: begin
                if (r_dir == pcf_pkg::DIR_DONE) begin
                    n_state = (r_depth == DPW'(1)) ? pcf_pkg::ST_CLEAR : pcf_pkg::ST_POP;
                end else begin
                    n_state = pcf_pkg::ST_CHECK;
                end
            end
            pcf_pkg::ST_CHECK: begin
                n_state = (!r_vis_q && (r_spa_q == r_old)) ? pcf_pkg::ST_DRAW
                                                            : pcf_pkg::ST_EXPAND;
            end
            pcf_pkg::ST_DRAW: begin
                if (r_half) n_state = pcf_pkg::ST_DECIDE;
            end
            pcf_pkg::ST_DECIDE: n_state = pcf_pkg::ST_EXPAND;
            pcf_pkg::ST_POP:    n_state = pcf_pkg::ST_EXPAND;
            pcf_pkg::ST_CLEAR: begin
                if (r_clr == LAST_SITE) n_state = pcf_pkg::ST_FINISH;
            end
            pcf_pkg::ST_BOND: begin
                if ((r_bidx == CELLS_D) && !r_bv) n_state = pcf_pkg::ST_FINISH;
            end
            pcf_pkg::ST_FINISH: begin
                if (out_free) n_state = pcf_pkg::ST_IDLE;
            end
            default: n_state = pcf_pkg::ST_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb begin
        n_site = r_site;   n_snew = r_snew;   n_old = r_old;
        n_top = r_top;     n_dir = r_dir;     n_nb = r_nb;
        n_depth = r_depth; n_tally = r_tally; n_res_spin = r_res_spin;
        n_status = r_status; n_half = r_half; n_clr = r_clr;
        n_bidx = r_bidx;   n_bv = r_bv;       n_bsite = r_bsite;
        n_first = r_first; n_prev = r_prev;
        spa_re = 1'b0; spb_re = 1'b0; sp_we = 1'b0;
        vis_re = 1'b0; vis_we = 1'b0; stk_re = 1'b0; stk_we = 1'b0;
        spa_addr = r_site; spb_addr = r_site; sp_waddr = r_site; sp_wdata = 1'b0;
        vis_raddr = nb_site; vis_waddr = r_nb; vis_wdata = 1'b1;
        stk_raddr = r_depth[AW-1:0] - AW'(2);
        stk_waddr = r_depth[AW-1:0] - AW'(1);
        stk_wdata = {r_dir, r_top};
        case (r_state)
            pcf_pkg::ST_INIT: begin
                sp_we = 1'b1;  sp_waddr = r_clr;  sp_wdata = 1'b0;
                vis_we = 1'b1; vis_waddr = r_clr; vis_wdata = 1'b0;
                n_clr = r_clr + AW'(1);
            end
            pcf_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_site = {i_in.row[CW-1:0], i_in.col[CW-1:0]};
                    n_snew = i_in.spin_value;
                    n_tally = '0; n_res_spin = 1'b0; n_status = 1'b0;
                    n_bidx = '0; n_bv = 1'b0;
                    spa_re = 1'b1;
                    spa_addr = {i_in.row[CW-1:0], i_in.col[CW-1:0]};
                    if (i_in.mode == pcf_pkg::MODE_WRITE) begin
                        sp_we = 1'b1;
                        sp_waddr = {i_in.row[CW-1:0], i_in.col[CW-1:0]};
                        sp_wdata = i_in.spin_value;
                    end
                end
            end
            pcf_pkg::ST_READ: n_res_spin = r_spa_q;
            pcf_pkg::ST_SEED: begin
                if (r_spa_q == r_snew) begin
                    n_status = 1'b1;
                end else begin
                    // Flag the seed and make it the only stack entry
                    vis_we = 1'b1; vis_waddr = r_site;
                    n_top = r_site; n_dir = pcf_pkg::DIR_RIGHT;
                    n_depth = DPW'(1); n_tally = 16'd1; n_old = r_spa_q;
                end
            end
            pcf_pkg::ST_EXPAND: begin
                if (r_dir == pcf_pkg::DIR_DONE) begin
                    // Retire the top site with the new spin and pop
                    sp_we = 1'b1; sp_waddr = r_top; sp_wdata = r_snew;
                    n_depth = r_depth - DPW'(1);
                    stk_re = (r_depth != DPW'(1));
                    n_clr = '0;
                end else begin
                    spa_re = 1'b1; spa_addr = nb_site;
                    vis_re = 1'b1;
                    n_nb = nb_site;
                    n_dir = r_dir + 3'd1;
                end
            end
            pcf_pkg::ST_CHECK: begin
                n_half = 1'b0;
                if (!(!r_vis_q && (r_spa_q == r_old))) vis_we = 1'b1;
            end
            pcf_pkg::ST_DRAW: n_half = 1'b1;
            pcf_pkg::ST_DECIDE: begin
                if (({1'b0, draw} < r_thr) && (r_depth < CELLS_D)) begin
                    // Push: save the current top below the entered neighbour
                    vis_we = 1'b1;
                    stk_we = 1'b1;
                    n_top = r_nb; n_dir = pcf_pkg::DIR_RIGHT;
                    n_depth = r_depth + DPW'(1);
                    n_tally = r_tally + 16'd1;
                end
            end
            pcf_pkg::ST_POP: begin
                n_top = r_stk_q[AW-1:0];
                n_dir = r_stk_q[STW-1:AW];
            end
            pcf_pkg::ST_CLEAR: begin
                vis_we = 1'b1; vis_waddr = r_clr; vis_wdata = 1'b0;
                n_clr = r_clr + AW'(1);
            end
            pcf_pkg::ST_BOND: begin
                if (r_bidx != CELLS_D) begin
                    spa_re = 1'b1; spa_addr = r_bidx[AW-1:0];
                    spb_re = 1'b1; spb_addr = r_bidx[AW-1:0] + AW'(pcf_pkg::SIDE);
                    n_bsite = r_bidx[AW-1:0];
                    n_bidx = r_bidx + DPW'(1);
                    n_bv = 1'b1;
                end else begin
                    n_bv = 1'b0;
                end
                if (r_bv) begin
                    n_tally = r_tally + 16'(bond_add);
                    n_prev = r_spa_q;
                    if (bcol == CW'(0)) n_first = r_spa_q;
                end
            end
            default: ;
        endcase
    end

    // Spin memory: one write port, two read ports
    always_ff @(posedge i_clk) begin
        if (sp_we) spin_mem[sp_waddr] <= sp_wdata;
        if (spa_re) r_spa_q <= spin_mem[spa_addr];
        if (spb_re) r_spb_q <= spin_mem[spb_addr];
    end

    // Flag memory
    always_ff @(posedge i_clk) begin
        if (vis_we) visit_mem[vis_waddr] <= vis_wdata;
        if (vis_re) r_vis_q <= visit_mem[vis_raddr];
    end

    // Walk stack memory
    always_ff @(posedge i_clk) begin
        if (stk_we) stack_mem[stk_waddr] <= stk_wdata;
        if (stk_re) r_stk_q <= stack_mem[stk_raddr];
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_site <= n_site;   r_snew <= n_snew;   r_old <= n_old;
        r_top <= n_top;     r_dir <= n_dir;     r_nb <= n_nb;
        r_tally <= n_tally; r_res_spin <= n_res_spin; r_status <= n_status;
        r_half <= n_half;   r_bidx <= n_bidx;   r_bsite <= n_bsite;
        r_first <= n_first; r_prev <= n_prev;
        if ((r_state == pcf_pkg::ST_FINISH) && out_free) begin
            r_o_spin   <= r_res_spin;
            r_o_tally  <= r_tally;
            r_o_status <= r_status;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcf_pkg::ST_INIT;
            r_clr   <= '0;
            r_depth <= '0;
            r_bv    <= 1'b0;
            r_ov    <= 1'b0;
            r_thr   <= pcf_pkg::THRESH_RESET;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_depth <= n_depth;
            r_bv    <= n_bv;
            if ((r_state == pcf_pkg::ST_FINISH) && out_free) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we && (i_cfg_idx == pcf_pkg::CFG_THRESH)) begin
                r_thr <= i_cfg_data[16:0];
            end
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.spin_read = r_o_spin;
    assign o_out.tally     = r_o_tally;
    assign o_out.status    = r_o_status;

`ifndef SYNTHESIS
    a_idle_empty_stack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pcf_pkg::ST_IDLE) |-> (r_depth == '0))
        else $error("walk stack not empty while idle");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= CELLS_D)
        else $error("walk stack depth beyond lattice size");

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stk_we && (r_state == pcf_pkg::ST_DECIDE)) |=> (r_depth == $past(r_depth) + DPW'(1)))
        else $error("push did not grow the stack");

    a_finish_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == pcf_pkg::ST_FINISH) && out_free) |=> r_ov)
        else $error("finished item left no result");
`endif

endmodule

// ===== dv/potts_cluster_flip_engine_tb.sv =====
// Testbench of the Potts cluster flip engine: directed and random items against a lattice model.
`timescale 1ns / 1ps

module potts_cluster_flip_engine_tb;

    localparam int  CYCLE_LIMIT = 4_000_000;
    localparam int  MAX_REPORTS = 10;

    typedef struct packed {
        logic        spin_read;
        logic [15:0] tally;
        logic        status;
    } t_result;

    logic i_clk;
    logic i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [31:0] i_cfg_data;

    pcf_in_if  in_ch ();
    pcf_out_if out_ch ();

    potts_cluster_flip_engine uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Lattice model state
    bit          lat_spin [pcf_pkg::CELLS];
    bit          lat_flag [pcf_pkg::CELLS];
    logic [31:0] walk_stack [pcf_pkg::CELLS];
    logic [16:0] bond_thresh;
    logic [31:0] lfsr_word;

    t_result     pending_results [$];
    int          mismatches;
    int          cycle_count;
    int          tx_idle_pct;
    int          rx_idle_pct;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Drive result ready with random stalls
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.spin_read, out_ch.tally, out_ch.status};
            if (pending_results.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < MAX_REPORTS)
                    $display("unexpected result: spin_read=%0d tally=%0d status=%0d",
                             got.spin_read, got.tally, got.status);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < MAX_REPORTS)
                        $display("mismatch: expected spin_read=%0d tally=%0d status=%0d, got %0d %0d %0d",
                                 want.spin_read, want.tally, want.status,
                                 got.spin_read, got.tally, got.status);
                end
            end
        end
    end

    function automatic logic [15:0] draw_bond();
        logic low;
        for (int k = 0; k < 16; k++) begin
            low = lfsr_word[0];
            lfsr_word = lfsr_word >> 1;
            if (low)
                lfsr_word ^= pcf_pkg::LFSR_TAPS;
        end
        return lfsr_word[15:0];
    endfunction

    function automatic int unsigned step_site(int unsigned site, int unsigned dir);
        logic [pcf_pkg::CW-1:0] r;
        logic [pcf_pkg::CW-1:0] c;
        r = site[pcf_pkg::AW-1:pcf_pkg::CW];
        c = site[pcf_pkg::CW-1:0];
        case (dir)
            0:       c = c + 1'b1;
            1:       c = c - 1'b1;
            2:       r = r + 1'b1;
            default: r = r - 1'b1;
        endcase
        return {r, c};
    endfunction

    // Depth-first Wolff growth; returns the cluster size
    function automatic int unsigned flip_cluster(int unsigned seed, bit new_spin);
        int unsigned size;
        int unsigned depth;
        int unsigned site;
        int unsigned dir;
        int unsigned nb;
        size = 1;
        depth = 1;
        lat_flag[seed] = 1'b1;
        walk_stack[0] = seed;
        while (depth > 0) begin
            site = walk_stack[depth-1][15:0];
            dir  = walk_stack[depth-1][31:16];
            if (dir >= 4) begin
                lat_spin[site] = new_spin;
                depth--;
            end else begin
                walk_stack[depth-1] = {16'(dir + 1), 16'(site)};
                nb = step_site(site, dir);
                if (!lat_flag[nb] && lat_spin[site] == lat_spin[nb]) begin
                    if (draw_bond() < bond_thresh && depth < pcf_pkg::CELLS) begin
                        lat_flag[nb] = 1'b1;
                        walk_stack[depth] = nb;
                        depth++;
                        size++;
                    end
                end else begin
                    lat_flag[nb] = 1'b1;
                end
            end
        end
        for (int s = 0; s < pcf_pkg::CELLS; s++)
            lat_flag[s] = 1'b0;
        return size;
    endfunction

    function automatic int unsigned count_bonds();
        int unsigned total;
        total = 0;
        for (int unsigned s = 0; s < pcf_pkg::CELLS; s++) begin
            if (lat_spin[s] == lat_spin[step_site(s, 0)])
                total++;
            if (lat_spin[s] == lat_spin[step_site(s, 2)])
                total++;
        end
        return total;
    endfunction

    function automatic t_result predict_item(pcf_pkg::t_mode mode, logic [6:0] row,
                                             logic [6:0] col, logic spin);
        t_result res;
        int unsigned site;
        res = '0;
        site = {row, col};
        case (mode)
            pcf_pkg::MODE_WRITE: lat_spin[site] = spin;
            pcf_pkg::MODE_READ:  res.spin_read = lat_spin[site];
            pcf_pkg::MODE_FLIP: begin
                if (lat_spin[site] == spin)
                    res.status = 1'b1;
                else
                    res.tally = 16'(flip_cluster(site, spin));
            end
            default:    res.tally = 16'(count_bonds());
        endcase
        return res;
    endfunction

    // Send one item; predict it at the transfer edge
    task automatic send_item(pcf_pkg::t_mode mode, logic [6:0] row, logic [6:0] col,
                             logic spin);
        if ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.mode       <= mode;
        in_ch.row        <= row;
        in_ch.col        <= col;
        in_ch.spin_value <= spin;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pending_results.push_back(predict_item(mode, row, col, spin));
    endtask

    // Hold off until every expected result has come
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write one register, then leave the write port idle
    task automatic write_reg(pcf_pkg::t_cfg_idx idx, logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == pcf_pkg::CFG_THRESH)
            bond_thresh = data[16:0];
        else
            lfsr_word = (data == 32'd0) ? 32'd1 : data;
        @(posedge i_clk);
    endtask

    task automatic test_reset_lattice();
        send_item(pcf_pkg::MODE_READ, 7'd0, 7'd0, 1'b1);
        send_item(pcf_pkg::MODE_READ, 7'd127, 7'd127, 1'b0);
        send_item(pcf_pkg::MODE_BOND, 7'd0, 7'd0, 1'b0);
    endtask

    task automatic test_spin_access();
        send_item(pcf_pkg::MODE_WRITE, 7'd0, 7'd0, 1'b1);
        send_item(pcf_pkg::MODE_WRITE, 7'd127, 7'd127, 1'b1);
        send_item(pcf_pkg::MODE_WRITE, 7'd0, 7'd127, 1'b1);
        send_item(pcf_pkg::MODE_WRITE, 7'd127, 7'd0, 1'b0);
        send_item(pcf_pkg::MODE_READ, 7'd0, 7'd0, 1'b0);
        send_item(pcf_pkg::MODE_READ, 7'd127, 7'd127, 1'b0);
        send_item(pcf_pkg::MODE_READ, 7'd0, 7'd127, 1'b0);
        send_item(pcf_pkg::MODE_READ, 7'd127, 7'd0, 1'b1);
    endtask

    task automatic test_same_spin();
        send_item(pcf_pkg::MODE_FLIP, 7'd5, 7'd5, 1'b0);
        send_item(pcf_pkg::MODE_FLIP, 7'd0, 7'd0, 1'b1);
    endtask

    // Threshold and seed extremes: never accept, always accept, zero seed
    task automatic test_threshold_extremes();
        drain();
        write_reg(pcf_pkg::CFG_THRESH, 32'd0);
        write_reg(pcf_pkg::CFG_SEED, 32'hFFFF_FFFF);
        send_item(pcf_pkg::MODE_FLIP, 7'd64, 7'd64, 1'b1);
        send_item(pcf_pkg::MODE_FLIP, 7'd0, 7'd0, 1'b0);
        drain();
        write_reg(pcf_pkg::CFG_THRESH, 32'h0001_FFFF);
        write_reg(pcf_pkg::CFG_SEED, 32'd0);
        send_item(pcf_pkg::MODE_FLIP, 7'd10, 7'd10, 1'b1);
        send_item(pcf_pkg::MODE_BOND, 7'd3, 7'd3, 1'b0);
        drain();
        write_reg(pcf_pkg::CFG_THRESH, 32'd65536);
        send_item(pcf_pkg::MODE_WRITE, 7'd1, 7'd1, 1'b0);
        send_item(pcf_pkg::MODE_FLIP, 7'd1, 7'd1, 1'b1);
        send_item(pcf_pkg::MODE_READ, 7'd1, 7'd1, 1'b0);
    endtask

    // Mostly spin traffic, with small-cluster flips and occasional bond sweeps
    task automatic test_random_traffic(int items, logic [16:0] thresh, logic [31:0] seed);
        int   pick;
        logic [6:0] row;
        logic [6:0] col;
        logic spin;
        drain();
        write_reg(pcf_pkg::CFG_THRESH, {15'd0, thresh});
        write_reg(pcf_pkg::CFG_SEED, seed);
        for (int n = 0; n < items; n++) begin
            pick = $urandom_range(99);
            row  = 7'($urandom);
            col  = 7'($urandom);
            spin = 1'($urandom);
            if (pick < 55)
                send_item(pcf_pkg::MODE_WRITE, row, col, spin);
            else if (pick < 84)
                send_item(pcf_pkg::MODE_READ, row, col, spin);
            else if (pick < 96)
                send_item(pcf_pkg::MODE_FLIP, row, col,
                          ($urandom_range(9) < 8) ? ~lat_spin[{row, col}] : spin);
            else
                send_item(pcf_pkg::MODE_BOND, row, col, spin);
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = pcf_pkg::CFG_THRESH;
        i_cfg_data       = '0;
        in_ch.valid      = 1'b0;
        in_ch.mode       = pcf_pkg::MODE_WRITE;
        in_ch.row        = '0;
        in_ch.col        = '0;
        in_ch.spin_value = 1'b0;
        out_ch.ready     = 1'b0;
        mismatches       = 0;
        cycle_count      = 0;
        tx_idle_pct      = 26;
        rx_idle_pct      = 69;
        bond_thresh      = pcf_pkg::THRESH_RESET;
        lfsr_word        = pcf_pkg::SEED_RESET;
        for (int s = 0; s < pcf_pkg::CELLS; s++) begin
            lat_spin[s] = 1'b0;
            lat_flag[s] = 1'b0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_lattice();
        test_spin_access();
        test_same_spin();
        test_threshold_extremes();

        test_random_traffic(34, 17'($urandom_range(20000)), 32'd0);
        tx_idle_pct = 69;
        rx_idle_pct = 26;
        test_random_traffic(33, 17'($urandom_range(1, 20000)), 32'hFFFF_FFFF);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_traffic(33, 17'($urandom_range(20000)), $urandom);

        drain();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
